// ----- rtl/core/multi_channel_timer_table_defines.svh -----
// Assertion helpers for the timer table
`ifndef MULTI_CHANNEL_TIMER_TABLE_DEFINES_SVH
`define MULTI_CHANNEL_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define MCTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mctt_pkg.sv -----
`timescale 1ns / 1ps
package mctt_pkg;

   localparam int NUM_TIMERS = 32;
   localparam int AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   localparam int ACT_W    = 3;
   localparam int IDX_W    = 5;
   localparam int PER_W    = 16;
   localparam int TICK_W   = 32;
   localparam int KIND_W   = 2;
   localparam int REQ_DW   = 56;
   localparam int RSP_DW   = 8;

   typedef enum logic [ACT_W-1:0] {
      ACT_CREATE   = 3'd0,
      ACT_RERUN    = 3'd1,
      ACT_STOP     = 3'd2,
      ACT_STOP_NOW = 3'd3,
      ACT_CHECK    = 3'd4
   } mctt_act_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK     = 2'd0,
      KIND_EXPIRED = 2'd1,
      KIND_NONE    = 2'd2
   } mctt_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_OP,
      ST_SCAN,
      ST_END
   } mctt_state_type;

   typedef struct packed {
      logic [TICK_W-1:0] deadline;
      logic [PER_W-1:0]  period;
      logic              mode;
   } mctt_entry_type;

   localparam int ENTRY_W = $bits(mctt_entry_type);

   localparam logic MODE_PERIODIC = 1'b0;
   localparam logic MODE_ONESHOT  = 1'b1;

   // wrap-aware "deadline is not after now"
   function automatic logic not_after(input logic [TICK_W-1:0] deadline,
                                      input logic [TICK_W-1:0] now);
      logic [TICK_W-1:0] diff;
      diff      = deadline - now;
      not_after = (diff == '0) || diff[TICK_W-1];
   endfunction

endpackage

// ----- rtl/core/mctt_ram.sv -----
`timescale 1ns / 1ps
module mctt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/multi_channel_timer_table.sv -----
`timescale 1ns / 1ps
// Timer table: NUM_TIMERS slots, each with active bit, deadline, period and mode.
// Request channel (req_*): one item per action; the action code rides in
// req_tuser, slot index, period, mode and the current tick in req_tdata.
// Result channel (rsp_*): kind in rsp_tuser, slot and previous mode in
// rsp_tdata, rsp_tlast on the final result of a request.
// Create, rerun, the stops and unknown codes give one acknowledge: the slot
// RAM is read at the accept edge; update, write-back and the result register
// load follow in ST_OP once the output register is free.
// Check walks the slots from the highest index down, one slot per cycle while
// the result channel does not stall the walk, through the single RAM read port.
// Each expired slot gives one result; if none expire a single "none" result.
// The last expiry is held one step so that it can carry rsp_tlast.
// One request is in work at a time; the next is taken once the current one
// has put its final result in the output register.
// A stalled result channel holds the output register and freezes the walk
// when a second result is ready; no result is lost.
// Reset clears the active bits and the control state; the RAM needs no clear.
module multi_channel_timer_table (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // timer_index[4:0], period[20:5], new_mode[21], now_tick[53:22], zeros
   input  logic [mctt_pkg::REQ_DW-1:0] req_tdata,
   // action[2:0]
   input  logic [mctt_pkg::ACT_W-1:0]  req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // expired_index[4:0], previous_mode[5], zeros
   output logic [mctt_pkg::RSP_DW-1:0] rsp_tdata,
   // kind[1:0]
   output logic [mctt_pkg::KIND_W-1:0] rsp_tuser,
   output logic                       rsp_tlast
);

   import mctt_pkg::*;

   `include "multi_channel_timer_table_defines.svh"

   mctt_state_type state_ff, state_in;

   logic [ACT_W-1:0]  act_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [PER_W-1:0]  per_ff;
   logic              nmode_ff;
   logic [TICK_W-1:0] now_ff;

   logic [AW-1:0]         scan_ff, scan_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;

   logic                rsp_valid_ff;
   mctt_kind_type       rsp_kind_ff;
   logic [IDX_W-1:0]    rsp_idx_ff;
   logic                rsp_pmode_ff;
   logic                rsp_last_ff;

   logic                req_take;
   logic                out_free;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   mctt_entry_type      ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_raw;
   mctt_entry_type      rd_entry;

   logic                act_wr_en;
   logic [AW-1:0]       act_wr_addr;
   logic                act_wr_val;

   logic                push;
   mctt_kind_type       push_kind;
   logic [IDX_W-1:0]    push_idx;
   logic                push_pmode;
   logic                push_last;

   logic                scan_hit;
   logic                scan_stall;
   logic                scan_advance;
   logic                idx_ok;
   logic [AW-1:0]       op_addr;

   assign rd_entry     = mctt_entry_type'(ram_rd_raw);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_take     = req_tvalid && req_tready;
   assign idx_ok       = ({1'b0, idx_ff} < (IDX_W + 1)'(NUM_TIMERS));
   assign op_addr      = idx_ff[AW-1:0];

   assign scan_hit     = active_ff[scan_ff] && not_after(rd_entry.deadline, now_ff);
   assign scan_stall   = scan_hit && pend_valid_ff && !out_free;
   assign scan_advance = (state_ff == ST_SCAN) && !scan_stall;

   mctt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_tuser == ACT_CHECK) ? ST_SCAN : ST_OP;
            end
         end
         ST_OP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_advance && scan_ff == '0) begin
               state_in = ST_END;
            end
         end
         ST_END: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ram_wr_en     = 1'b0;
      ram_wr_addr   = op_addr;
      ram_wr_data   = rd_entry;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = req_tdata[AW-1:0];
      act_wr_en     = 1'b0;
      act_wr_addr   = op_addr;
      act_wr_val    = 1'b0;
      push          = 1'b0;
      push_kind     = KIND_ACK;
      push_idx      = '0;
      push_pmode    = 1'b0;
      push_last     = 1'b1;
      scan_in       = scan_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ram_rd_en     = 1'b1;
               pend_valid_in = 1'b0;
               if (req_tuser == ACT_CHECK) begin
                  ram_rd_addr = AW'(NUM_TIMERS - 1);
                  scan_in     = AW'(NUM_TIMERS - 1);
               end
            end
         end
         ST_OP: begin
            if (out_free) begin
               push = 1'b1;
               if (idx_ok) begin
                  unique case (act_ff)
                     ACT_CREATE: begin
                        ram_wr_en            = 1'b1;
                        ram_wr_data.deadline = now_ff + TICK_W'(per_ff);
                        ram_wr_data.period   = per_ff;
                        ram_wr_data.mode     = nmode_ff;
                        act_wr_en            = 1'b1;
                        act_wr_val           = 1'b1;
                     end
                     ACT_RERUN: begin
                        ram_wr_en            = 1'b1;
                        ram_wr_data.deadline = now_ff + TICK_W'(rd_entry.period);
                        ram_wr_data.mode     = nmode_ff;
                        act_wr_en            = 1'b1;
                        act_wr_val           = 1'b1;
                        push_pmode           = rd_entry.mode;
                     end
                     ACT_STOP: begin
                        ram_wr_en        = 1'b1;
                        ram_wr_data.mode = MODE_ONESHOT;
                        push_pmode       = rd_entry.mode;
                     end
                     ACT_STOP_NOW: begin
                        ram_wr_en            = 1'b1;
                        ram_wr_data.deadline = '0;
                        ram_wr_data.mode     = MODE_ONESHOT;
                        act_wr_en            = 1'b1;
                        act_wr_val           = 1'b0;
                        push_pmode           = rd_entry.mode;
                     end
                     default: begin
                        ram_wr_en = 1'b0;
                     end
                  endcase
               end
            end
         end
         ST_SCAN: begin
            ram_wr_addr = scan_ff;
            act_wr_addr = scan_ff;
            if (scan_advance) begin
               if (scan_hit) begin
                  ram_wr_en = 1'b1;
                  if (rd_entry.mode == MODE_PERIODIC) begin
                     ram_wr_data.deadline = rd_entry.deadline + TICK_W'(rd_entry.period);
                  end else begin
                     ram_wr_data.deadline = '0;
                     act_wr_en            = 1'b1;
                     act_wr_val           = 1'b0;
                  end
                  if (pend_valid_ff) begin
                     push      = 1'b1;
                     push_kind = KIND_EXPIRED;
                     push_idx  = pend_idx_ff;
                     push_last = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = IDX_W'(scan_ff);
               end
               if (scan_ff != '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = scan_ff - 1'b1;
                  scan_in     = scan_ff - 1'b1;
               end
            end
         end
         ST_END: begin
            if (out_free) begin
               push          = 1'b1;
               pend_valid_in = 1'b0;
               if (pend_valid_ff) begin
                  push_kind = KIND_EXPIRED;
                  push_idx  = pend_idx_ff;
               end else begin
                  push_kind = KIND_NONE;
               end
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase

      active_in = active_ff;
      if (act_wr_en) begin
         active_in[act_wr_addr] = act_wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      if (req_take) begin
         act_ff   <= req_tuser;
         idx_ff   <= req_tdata[4:0];
         per_ff   <= req_tdata[20:5];
         nmode_ff <= req_tdata[21];
         now_ff   <= req_tdata[53:22];
      end
      if (push) begin
         rsp_kind_ff  <= push_kind;
         rsp_idx_ff   <= push_idx;
         rsp_pmode_ff <= push_pmode;
         rsp_last_ff  <= push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(RSP_DW - IDX_W - 1){1'b0}}, rsp_pmode_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   `MCTT_ASSERT_NEXT(a_take_starts_work, clock, reset, req_take,
      (state_ff == ST_OP || state_ff == ST_SCAN), "accepted item did not start work")
   `MCTT_ASSERT_NOW(a_pend_in_check, clock, reset, pend_valid_ff,
      (state_ff == ST_SCAN || state_ff == ST_END), "held expiry outside a check")
   `MCTT_ASSERT_NEXT(a_scan_push_not_last, clock, reset, (push && state_ff == ST_SCAN),
      (!rsp_tlast && rsp_tuser == KIND_EXPIRED), "mid-walk result marked last")

endmodule

// ----- dv/timer_table_checker.sv -----
`timescale 1ns / 1ps
module timer_table_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [mctt_pkg::REQ_DW-1:0] req_tdata,
   input  logic [mctt_pkg::ACT_W-1:0]  req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [mctt_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic [mctt_pkg::KIND_W-1:0] rsp_tuser,
   input  logic                        rsp_tlast,
   output int                          mismatches,
   output int                          outstanding,
   output int                          results_seen,
   output int                          expiries_seen,
   output int                          widest_burst
);

   import mctt_pkg::*;

   typedef struct packed {
      mctt_kind_type    kind;
      logic [IDX_W-1:0] slot;
      logic             prev_mode;
      logic             last;
   } report_type;

   logic              armed    [NUM_TIMERS];
   logic [TICK_W-1:0] deadline [NUM_TIMERS];
   logic [PER_W-1:0]  period   [NUM_TIMERS];
   logic              mode     [NUM_TIMERS];
   report_type        timer_reports[$];
   report_type        want;
   report_type        got;

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      results_seen  = 0;
      expiries_seen = 0;
      widest_burst  = 0;
   end

   task automatic run_action(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                             input logic [PER_W-1:0] per, input logic nmode,
                             input logic [TICK_W-1:0] now);
      int                n;
      logic              old;
      logic              have_held;
      logic [TICK_W-1:0] diff;
      report_type        held;
      n         = 0;
      have_held = 1'b0;
      held      = '0;
      if (act == ACT_CHECK) begin
         for (int s = NUM_TIMERS - 1; s >= 0; s--) begin
            diff = deadline[s] - now;
            if (armed[s] && (diff == '0 || diff[TICK_W-1])) begin
               if (have_held) begin
                  timer_reports.push_back(held);
               end
               held      = report_type'{KIND_EXPIRED, IDX_W'(s), 1'b0, 1'b0};
               have_held = 1'b1;
               n++;
               if (mode[s] == MODE_PERIODIC) begin
                  deadline[s] = deadline[s] + TICK_W'(period[s]);
               end else begin
                  armed[s]    = 1'b0;
                  deadline[s] = '0;
               end
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            timer_reports.push_back(held);
         end else begin
            timer_reports.push_back(report_type'{KIND_NONE, '0, 1'b0, 1'b1});
         end
         if (n > widest_burst) widest_burst = n;
         return;
      end
      if (act > ACT_CHECK || int'(idx) >= NUM_TIMERS) begin
         timer_reports.push_back(report_type'{KIND_ACK, '0, 1'b0, 1'b1});
         return;
      end
      old = mode[idx];
      case (mctt_act_type'(act))
         ACT_CREATE: begin
            period[idx]   = per;
            mode[idx]     = nmode;
            deadline[idx] = now + TICK_W'(per);
            armed[idx]    = 1'b1;
            old           = 1'b0;
         end
         ACT_RERUN: begin
            deadline[idx] = now + TICK_W'(period[idx]);
            armed[idx]    = 1'b1;
            mode[idx]     = nmode;
         end
         ACT_STOP: begin
            mode[idx] = MODE_ONESHOT;
         end
         default: begin
            armed[idx]    = 1'b0;
            deadline[idx] = '0;
            mode[idx]     = MODE_ONESHOT;
         end
      endcase
      timer_reports.push_back(report_type'{KIND_ACK, '0, old, 1'b1});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_TIMERS; s++) begin
            armed[s]    = 1'b0;
            deadline[s] = '0;
            period[s]   = '0;
            mode[s]     = 1'b0;
         end
         timer_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.kind      = mctt_kind_type'(rsp_tuser);
            got.slot      = rsp_tdata[IDX_W-1:0];
            got.prev_mode = rsp_tdata[IDX_W];
            got.last      = rsp_tlast;
            if (got.kind == KIND_EXPIRED) expiries_seen++;
            if (timer_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result kind %0d slot %0d prev %0d last %0d",
                           $time, got.kind, got.slot, got.prev_mode, got.last);
            end else begin
               want = timer_reports.pop_front();
               if (got.kind !== want.kind || got.slot !== want.slot ||
                   got.prev_mode !== want.prev_mode || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: kind/slot/prev/last want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              $time, want.kind, want.slot, want.prev_mode, want.last,
                              got.kind, got.slot, got.prev_mode, got.last);
               end
            end
         end
         if (req_tvalid && req_tready)
            run_action(req_tuser, req_tdata[IDX_W-1:0], req_tdata[IDX_W +: PER_W],
                       req_tdata[IDX_W+PER_W], req_tdata[IDX_W+PER_W+1 +: TICK_W]);
      end
      outstanding <= timer_reports.size();
   end

endmodule

// ----- dv/tb_multi_channel_timer_table.sv -----
`timescale 1ns / 1ps
module tb_multi_channel_timer_table;
   import mctt_pkg::*;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata  = '0;
   logic [ACT_W-1:0]    req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic [KIND_W-1:0]   rsp_tuser;
   logic                rsp_tlast;

   int mismatches;
   int outstanding;
   int results_seen;
   int expiries_seen;
   int widest_burst;

   int                items      = 0;
   int                gap_odds   = 0;
   int                stall_odds = 0;
   int                stall_left = 0;
   logic              created [NUM_TIMERS];
   logic [TICK_W-1:0] now_t;

   multi_channel_timer_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   timer_table_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .results_seen  (results_seen),
      .expiries_seen (expiries_seen),
      .widest_burst  (widest_burst)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send(input logic [ACT_W-1:0] act, input int slot,
                       input logic [PER_W-1:0] per, input logic md,
                       input logic [TICK_W-1:0] now);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {2'b00, now, md, per, IDX_W'(slot)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act == ACT_CREATE) created[slot] = 1'b1;
      items++;
   endtask

   task automatic check_at(input logic [TICK_W-1:0] now);
      send(ACT_CHECK, $urandom_range(0, NUM_TIMERS - 1), PER_W'($urandom), 1'($urandom), now);
   endtask

   task automatic slot_op(input mctt_act_type op, input int slot, input logic md);
      send(op, slot, PER_W'($urandom), md, now_t);
   endtask

   function automatic int some_created();
      int s;
      s = $urandom_range(0, NUM_TIMERS - 1);
      for (int k = 0; k < NUM_TIMERS; k++)
         if (created[(s + k) % NUM_TIMERS]) return (s + k) % NUM_TIMERS;
      return 0;
   endfunction

   function automatic int pick_odds();
      return ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(1, 4));
   endfunction

   function automatic logic [PER_W-1:0] pick_period();
      return ($urandom_range(0, 7) == 0) ? PER_W'($urandom) : PER_W'($urandom_range(0, 200));
   endfunction

   initial begin
      logic [TICK_W-1:0] t0;
      int                kind_pick;
      for (int s = 0; s < NUM_TIMERS; s++) created[s] = 1'b0;
      repeat (4) @(posedge clock);
      reset      <= 1'b0;
      gap_odds    = 4;
      stall_odds <= 6;

      // directed
      t0    = 32'h0000_1000;
      now_t = t0;
      check_at(t0);
      for (int a = int'(ACT_CHECK) + 1; a < 2 ** ACT_W; a++)
         send(ACT_W'(a), $urandom_range(0, NUM_TIMERS - 1), PER_W'($urandom), 1'($urandom), t0);
      send(ACT_CREATE, 0, 16'd0, MODE_PERIODIC, t0);
      send(ACT_CREATE, NUM_TIMERS - 1, 16'hFFFF, MODE_ONESHOT, t0);
      send(ACT_CREATE, 5, 16'd10, MODE_PERIODIC, t0);
      send(ACT_CREATE, 6, 16'd10, MODE_ONESHOT, t0);
      check_at(t0);
      check_at(t0 + 10);
      send(ACT_RERUN, 6, 16'd0, MODE_PERIODIC, t0 + 10);
      send(ACT_STOP, 5, 16'd0, MODE_PERIODIC, t0 + 10);
      check_at(t0 + 20);
      send(ACT_STOP_NOW, 0, 16'd0, MODE_PERIODIC, t0 + 20);
      send(ACT_STOP_NOW, 0, 16'd0, MODE_PERIODIC, t0 + 20);
      send(ACT_RERUN, 0, 16'd0, MODE_ONESHOT, t0 + 20);
      check_at(t0 + 32'd65555);
      send(ACT_CREATE, 10, 16'h0020, MODE_PERIODIC, 32'hFFFF_FFF0);
      check_at(32'hFFFF_FFF8);
      check_at(32'h0000_0010);
      send(ACT_CREATE, 20, 16'd0, MODE_ONESHOT, 32'h8000_0000);
      check_at(32'h0000_0001);
      check_at(32'h0000_0000);

      // random
      now_t = $urandom;
      while (items < 270) begin
         if (items > 240) begin
            gap_odds    = 0;
            stall_odds <= 0;
         end else begin
            gap_odds    = pick_odds();
            stall_odds <= pick_odds();
         end
         kind_pick = $urandom_range(0, 19);
         if (kind_pick < 2 && items < 200) begin
            // arm every slot, then sweep them all in one check
            for (int s = 0; s < NUM_TIMERS; s++)
               send(ACT_CREATE, s, PER_W'($urandom_range(0, 40)), 1'($urandom), now_t);
            now_t += 50;
            check_at(now_t);
         end else if (kind_pick < 4) begin
            case ($urandom_range(0, 2))
               0: send(ACT_W'($urandom_range(int'(ACT_CHECK) + 1, 2 ** ACT_W - 1)),
                       $urandom_range(0, NUM_TIMERS - 1), PER_W'($urandom), 1'($urandom),
                       $urandom);
               1: check_at($urandom);
               default: send(ACT_CREATE, $urandom_range(0, NUM_TIMERS - 1), PER_W'($urandom),
                             1'($urandom), $urandom);
            endcase
         end else if (kind_pick == 4) begin
            now_t = 32'hFFFF_FFFF - $urandom_range(0, 300);
            check_at(now_t);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0)
                  send(ACT_CREATE, $urandom_range(0, NUM_TIMERS - 1), pick_period(),
                       1'($urandom), now_t);
               else
                  slot_op(mctt_act_type'($urandom_range(int'(ACT_RERUN), int'(ACT_STOP_NOW))),
                          some_created(), 1'($urandom));
            end
            now_t += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000)
                                                 : $urandom_range(0, 150);
            check_at(now_t);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d requests, %0d results checked, %0d expiries, widest check %0d",
               items, results_seen, expiries_seen, widest_burst);
      $display("all actions, unknown codes, tick wraparound and full-table sweeps exercised");
      if (mismatches == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
